// ===== src/first_fit_block_allocator_assert.svh =====
// Assertion macros used by the allocator controller.
// Included by files that check their own control logic; no other dependencies.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define FFBA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, disabled while reset is high.
`define FFBA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// ===== src/ffba_pkg.sv =====
// Shared types and constants of the first-fit block allocator.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package ffba_pkg;

  localparam int LEN_W   = 10;
  localparam int ENTRY_W = 11;
  localparam int POOL_W  = 11;
  localparam int H_W     = 12;
  localparam int WANT_W  = 12;
  localparam int HDR_LIMIT = 1024;

  localparam logic [POOL_W-1:0] POOL_RESET = 11'd1024;
  localparam logic [POOL_W-1:0] POOL_MIN   = 11'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_TAKE_WANT,
    WR_TAKE_WHOLE,
    WR_SPLIT_TAIL,
    WR_FREE_SOLO,
    WR_FREE_MERGE
  } wr_t;

  typedef enum logic [2:0] {
    FIN_NONE,
    FIN_FAIL,
    FIN_WANT,
    FIN_LEN,
    FIN_FREE
  } fin_t;

  typedef struct packed {
    logic load;
    logic rd_cur;
    logic rd_next;
    logic step;
    logic keep_len;
    wr_t  wr;
    fin_t fin;
    logic publish;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic h_in_pool;
    logic h_below_target;
    logic h_at_target;
    logic fits;
    logic split;
    logic nxt_in_pool;
    logic next_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== src/ffba_dp.sv =====
// Datapath of the allocator: header memory, walk pointer, compares and result registers.
// Depends on ffba_pkg; driven by the commands of ffba_ctrl.
`default_nettype none

module ffba_dp #(
  parameter int POOL_DEPTH = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire ffba_pkg::cmd_t              cmd,
  output ffba_pkg::sts_t                   sts,
  input  wire logic [23:0]                 s_tdata,
  input  wire logic [0:0]                  s_tuser,
  input  wire logic                        cfg_we,
  input  wire logic [ffba_pkg::POOL_W-1:0] cfg_wdata,
  output logic      [23:0]                 m_tdata,
  output logic      [0:0]                  m_tuser
);
  import ffba_pkg::*;

  localparam int AW  = $clog2(POOL_DEPTH);
  localparam int LIM = (POOL_DEPTH < HDR_LIMIT) ? POOL_DEPTH : HDR_LIMIT;
  localparam logic [POOL_W-1:0] LIM_V = POOL_W'(LIM);

  function automatic logic [POOL_W-1:0] live_pool(input logic [POOL_W-1:0] pw);
    logic [POOL_W-1:0] v;
    v = pw;
    if (v < POOL_MIN) v = POOL_MIN;
    if (v > LIM_V) v = LIM_V;
    return v;
  endfunction

  logic [ENTRY_W-1:0] mem [POOL_DEPTH];
  logic [ENTRY_W-1:0] rd_data;

  logic [POOL_W-1:0] pool;
  logic [POOL_W-1:0] p;
  op_t               op_r;
  logic [WANT_W-1:0] want;
  logic [LEN_W-1:0]  target;
  logic [H_W-1:0]    h;
  logic [LEN_W-1:0]  cur_len;

  logic             res_status;
  logic [LEN_W-1:0] res_hdr;
  logic [LEN_W-1:0] res_granted;
  logic             out_status;
  logic [LEN_W-1:0] out_hdr;
  logic [LEN_W-1:0] out_granted;

  logic [LEN_W-1:0]   rd_len;
  logic [H_W-1:0]     nxt;
  logic [H_W-1:0]     step_h;
  logic [H_W-1:0]     tail_h;
  logic [POOL_W-1:0]  fmt_pool;
  logic               fmt;
  logic               wr_en;
  logic [H_W-1:0]     wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic               rd_en;
  logic [H_W-1:0]     rd_addr;
  logic [13:0]        bytes_up;
  logic [12:0]        want_plus3;
  logic [LEN_W-1:0]   merged_len;
  logic [H_W-1:0]     tail_len;

  assign p          = live_pool(pool);
  assign rd_len     = rd_data[LEN_W-1:0];
  assign nxt        = h + H_W'(1) + H_W'(cur_len);
  assign step_h     = h + H_W'(1) + H_W'(rd_len);
  assign tail_h     = h + H_W'(1) + want;
  assign tail_len   = H_W'(cur_len) - want - H_W'(1);
  assign merged_len = cur_len + LEN_W'(1) + rd_len;
  assign bytes_up   = {1'b0, s_tdata[12:0]} + 14'd3;
  assign want_plus3 = {1'b0, want} + 13'd3;
  assign fmt        = rst || cfg_we;
  assign fmt_pool   = live_pool(rst ? POOL_RESET : cfg_wdata);

  always_comb begin
    sts.op             = op_r;
    sts.h_in_pool      = h < H_W'(p);
    sts.h_below_target = h < H_W'(target);
    sts.h_at_target    = h == H_W'(target);
    sts.fits           = !rd_data[ENTRY_W-1] && (WANT_W'(rd_len) >= want);
    sts.split          = 13'(rd_len) >= want_plus3;
    sts.nxt_in_pool    = nxt < H_W'(p);
    sts.next_free      = !rd_data[ENTRY_W-1];
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = h;
    wr_data = '0;
    case (cmd.wr)
      WR_TAKE_WANT:  wr_data = {1'b1, want[LEN_W-1:0]};
      WR_TAKE_WHOLE: wr_data = {1'b1, rd_len};
      WR_SPLIT_TAIL: begin
        wr_addr = tail_h;
        wr_data = {1'b0, tail_len[LEN_W-1:0]};
      end
      WR_FREE_SOLO:  wr_data = {1'b0, cur_len};
      WR_FREE_MERGE: wr_data = {1'b0, merged_len};
      default:       wr_en = 1'b0;
    endcase
    if (fmt) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = {1'b0, LEN_W'(fmt_pool - POOL_W'(1))};
    end
  end

  assign rd_en   = cmd.rd_cur || cmd.rd_next;
  assign rd_addr = cmd.rd_next ? nxt : h;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(wr_addr)] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[AW'(rd_addr)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool <= POOL_RESET;
    end else if (cfg_we) begin
      pool <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_t'(s_tuser[0]);
      want   <= bytes_up[13:2];
      target <= s_tdata[22:13];
      h      <= '0;
    end else if (cmd.step) begin
      h <= step_h;
    end
    if (cmd.keep_len) begin
      cur_len <= rd_len;
    end
    case (cmd.fin)
      FIN_FAIL: begin
        res_status  <= STATUS_FAIL;
        res_hdr     <= '0;
        res_granted <= '0;
      end
      FIN_WANT: begin
        res_status  <= STATUS_OK;
        res_hdr     <= h[LEN_W-1:0];
        res_granted <= want[LEN_W-1:0];
      end
      FIN_LEN: begin
        res_status  <= STATUS_OK;
        res_hdr     <= h[LEN_W-1:0];
        res_granted <= rd_len;
      end
      FIN_FREE: begin
        res_status  <= STATUS_OK;
        res_hdr     <= '0;
        res_granted <= '0;
      end
      default: ;
    endcase
    if (cmd.publish) begin
      out_status  <= res_status;
      out_hdr     <= res_hdr;
      out_granted <= res_granted;
    end
  end

  assign m_tdata = {4'b0000, out_granted, out_hdr};
  assign m_tuser = out_status;

endmodule

`default_nettype wire

// ===== src/ffba_ctrl.sv =====
// Controller of the allocator: walks headers by issuing commands to ffba_dp.
// Depends on ffba_pkg and the assertion macro header.
`default_nettype none
`include "first_fit_block_allocator_assert.svh"

module ffba_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  input  wire ffba_pkg::sts_t sts,
  output ffba_pkg::cmd_t      cmd
);
  import ffba_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EV,
    ST_SPLIT,
    ST_FHDR,
    ST_FNX,
    ST_FMG,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    cmd.wr     = WR_NONE;
    cmd.fin    = FIN_NONE;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid && s_tready) begin
          cmd.load   = 1'b1;
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        if (sts.op == OP_ALLOC) begin
          if (sts.h_in_pool) begin
            cmd.rd_cur = 1'b1;
            state_next = ST_EV;
          end else begin
            cmd.fin    = FIN_FAIL;
            state_next = ST_DONE;
          end
        end else if (sts.h_in_pool && sts.h_below_target) begin
          cmd.rd_cur = 1'b1;
          state_next = ST_EV;
        end else if (sts.h_in_pool && sts.h_at_target) begin
          cmd.rd_cur = 1'b1;
          state_next = ST_FHDR;
        end else begin
          cmd.fin    = FIN_FAIL;
          state_next = ST_DONE;
        end
      end
      ST_EV: begin
        if (sts.op == OP_ALLOC && sts.fits) begin
          if (sts.split) begin
            cmd.wr       = WR_TAKE_WANT;
            cmd.keep_len = 1'b1;
            state_next   = ST_SPLIT;
          end else begin
            cmd.wr     = WR_TAKE_WHOLE;
            cmd.fin    = FIN_LEN;
            state_next = ST_DONE;
          end
        end else begin
          cmd.step   = 1'b1;
          state_next = ST_RD;
        end
      end
      ST_SPLIT: begin
        cmd.wr     = WR_SPLIT_TAIL;
        cmd.fin    = FIN_WANT;
        state_next = ST_DONE;
      end
      ST_FHDR: begin
        cmd.keep_len = 1'b1;
        state_next   = ST_FNX;
      end
      ST_FNX: begin
        if (sts.nxt_in_pool) begin
          cmd.rd_next = 1'b1;
          state_next  = ST_FMG;
        end else begin
          cmd.wr     = WR_FREE_SOLO;
          cmd.fin    = FIN_FREE;
          state_next = ST_DONE;
        end
      end
      ST_FMG: begin
        cmd.wr     = sts.next_free ? WR_FREE_MERGE : WR_FREE_SOLO;
        cmd.fin    = FIN_FREE;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      s_tready <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      s_tready <= state_next == ST_IDLE;
      if (cmd.publish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `FFBA_ASSERT_IMP(a_ready_only_idle, clk, rst, s_tready, state == ST_IDLE)
  `FFBA_ASSERT_IMP(a_no_overwrite, clk, rst, m_tvalid && !m_tready, !cmd.publish)
  `FFBA_ASSERT_NXT(a_one_in_flight, clk, rst, s_tvalid && s_tready, !s_tready)

endmodule

`default_nettype wire

// ===== src/first_fit_block_allocator.sv =====
// First-fit block allocator over a pool of words laid out as an implicit block list.
//
// Input channel s_*: one beat is one request. s_tuser selects allocate (0) or free (1);
// s_tdata carries the byte count to allocate and the header offset to free.
// Output channel m_*: one beat per request with the status in m_tuser and the
// header offset and granted payload words in m_tdata (both zero on failure and on free).
// Configuration: pool_words_we with pool_words_wdata sets the pool size and
// reformats the pool as one free block; write it only while no request is open.
// Steps per request, from one accept to the next: an allocate reads and evaluates each
// header visited, adds a split step when the block is split and then posts the result,
// or posts a failure when no block fits; a free walks the headers before its own, then
// reads its own header and the next for the optional merge, or fails on a non-header offset.
// The result appears in the same cycle that the next request can be taken.
// The walk is bound by the single read port of the header memory, one header read
// and one evaluation per visited block, so throughput follows pool fragmentation.
// Reset writes the single free header at entry 0 in the reset cycle; no sweep runs.
// s_tready is low during reset and rises in the cycle after reset is released.
// A result waits in the output register while m_tready is low; the next request
// is taken meanwhile and its result is held until the output register empties.
`default_nettype none

module first_fit_block_allocator #(
  parameter int POOL_DEPTH = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [23:0]                 s_tdata,  // request_bytes[12:0], block_offset[22:13]
  input  wire logic [0:0]                  s_tuser,  // op[0]
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic      [23:0]                 m_tdata,  // header_offset[9:0], granted_words[19:10]
  output logic      [0:0]                  m_tuser,  // status[0]
  input  wire logic                        pool_words_we,
  input  wire logic [ffba_pkg::POOL_W-1:0] pool_words_wdata
);
  import ffba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ffba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffba_dp #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (pool_words_we),
    .cfg_wdata (pool_words_wdata),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

`default_nettype wire

// ===== tb/first_fit_block_allocator_tb.sv =====
// Self-checking testbench for first_fit_block_allocator, the first-fit allocator over
// an implicit block list. It predicts every answer from its own copy of the header
// store and depends only on ffba_pkg and the allocator RTL.
`timescale 1ns / 1ps

module first_fit_block_allocator_tb;
  import ffba_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int PHASES = 10;

  typedef struct packed {
    logic           status;
    logic [9:0]     header_offset;
    logic [9:0]     granted_words;
  } alloc_answer_t;

  // Tracks the block layout of the pool and the answers still owed by the block.
  class pool_model;
    bit [ENTRY_W-1:0] headers [HDR_LIMIT];
    bit [POOL_W-1:0]  pool_reg;
    alloc_answer_t    due_answers [$];
    int               errors;

    function new();
      set_pool(POOL_RESET);
      errors = 0;
    endfunction

    function int live_words();
      int p;
      p = pool_reg;
      if (p < 2) p = 2;
      if (p > HDR_LIMIT) p = HDR_LIMIT;
      return p;
    endfunction

    function void set_pool(bit [POOL_W-1:0] value);
      pool_reg = value;
      foreach (headers[i]) headers[i] = '0;
      headers[0] = ENTRY_W'(live_words() - 1);
    endfunction

    function int outstanding();
      return due_answers.size();
    endfunction

    function int largest_free();
      int h, best, p;
      h = 0;
      best = 0;
      p = live_words();
      while (h < p) begin
        if (!headers[h][LEN_W] && headers[h][LEN_W-1:0] > best) best = headers[h][LEN_W-1:0];
        h = h + 1 + headers[h][LEN_W-1:0];
      end
      return best;
    endfunction

    function int pick_header(bit busy);
      int cands [$];
      int h, p;
      h = 0;
      p = live_words();
      while (h < p) begin
        if (headers[h][LEN_W] == busy) cands.push_back(h);
        h = h + 1 + headers[h][LEN_W-1:0];
      end
      if (cands.size() == 0) return -1;
      return cands[$urandom_range(0, cands.size() - 1)];
    endfunction

    function void apply_request(op_t op, logic [12:0] bytes, logic [9:0] target);
      alloc_answer_t ans;
      int p, h, want, len, nxt;
      p = live_words();
      h = 0;
      ans = '{status: STATUS_FAIL, header_offset: '0, granted_words: '0};
      if (op == OP_ALLOC) begin
        want = (int'(bytes) + 3) >> 2;
        while (h < p) begin
          len = headers[h][LEN_W-1:0];
          if (!headers[h][LEN_W] && len >= want) begin
            if (len >= want + 3) begin
              headers[h] = {1'b1, LEN_W'(want)};
              headers[h + 1 + want] = ENTRY_W'(len - want - 1);
              ans.granted_words = LEN_W'(want);
            end else begin
              headers[h][LEN_W] = 1'b1;
              ans.granted_words = LEN_W'(len);
            end
            ans.status = STATUS_OK;
            ans.header_offset = LEN_W'(h);
            break;
          end
          h = h + 1 + len;
        end
      end else begin
        while (h < p && h < int'(target)) h = h + 1 + headers[h][LEN_W-1:0];
        if (h == int'(target) && h < p) begin
          len = headers[h][LEN_W-1:0];
          nxt = h + 1 + len;
          if (nxt < p && !headers[nxt][LEN_W]) len = len + 1 + headers[nxt][LEN_W-1:0];
          headers[h] = ENTRY_W'(len);
          ans.status = STATUS_OK;
        end
      end
      due_answers.push_back(ans);
    endfunction

    function void check_answer(logic status, logic [9:0] hdr, logic [9:0] granted);
      alloc_answer_t exp;
      if (due_answers.size() == 0) begin
        $error("Result beat arrived with no request outstanding.");
        errors++;
        return;
      end
      exp = due_answers.pop_front();
      if (status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, status);
        errors++;
      end
      if (hdr !== exp.header_offset) begin
        $error("header_offset: expected %0d, actual %0d", exp.header_offset, hdr);
        errors++;
      end
      if (granted !== exp.granted_words) begin
        $error("granted_words: expected %0d, actual %0d", exp.granted_words, granted);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [23:0]       s_tdata;  // request_bytes[12:0], block_offset[22:13]
  logic [0:0]        s_tuser;  // op[0]
  logic              m_tvalid;
  logic              m_tready;
  logic [23:0]       m_tdata;  // header_offset[9:0], granted_words[19:10]
  logic [0:0]        m_tuser;  // status[0]
  logic              pool_words_we;
  logic [POOL_W-1:0] pool_words_wdata;

  pool_model model;
  int        burst_left;
  bit        gapless;
  int        long_holds_asked;

  first_fit_block_allocator uut (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .s_tuser          (s_tuser),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tuser          (m_tuser),
    .pool_words_we    (pool_words_we),
    .pool_words_wdata (pool_words_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic offer(input op_t op, input logic [12:0] bytes, input logic [9:0] offset);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 15);
      burst_left = $urandom_range(1, 24);
      if (gap > 0 && !gapless) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, offset, bytes};
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    model.apply_request(op, bytes, offset);
  endtask

  task automatic req_alloc(input int bytes);
    offer(OP_ALLOC, 13'(bytes), 10'($urandom_range(0, 1023)));
  endtask

  task automatic req_free(input int offset);
    offer(OP_FREE, 13'($urandom_range(0, 8191)), 10'(offset));
  endtask

  task automatic write_pool(input logic [POOL_W-1:0] value);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (model.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    pool_words_we    <= 1'b1;
    pool_words_wdata <= value;
    @(posedge clk);
    pool_words_we <= 1'b0;
    model.set_pool(value);
  endtask

  task automatic random_request();
    int r, lf, cap, hh;
    r = $urandom_range(0, 99);
    lf = model.largest_free();
    if (r < 55) begin
      r = $urandom_range(0, 9);
      cap = model.live_words() < 48 ? model.live_words() : 48;
      if (r < 6) req_alloc($urandom_range(0, 4 * cap));
      else if (r < 8) req_alloc($urandom_range(lf * 4 > 12 ? lf * 4 - 12 : 0, lf * 4 + 4));
      else req_alloc($urandom_range(0, 8191));
    end else begin
      r = $urandom_range(0, 9);
      if (r < 7) hh = model.pick_header(1'b1);
      else if (r < 8) hh = model.pick_header(1'b0);
      else hh = -1;
      req_free(hh < 0 ? $urandom_range(0, 1023) : hh);
    end
  endtask

  // Result side: stall patterns change every so often, plus long hold-offs on request.
  initial begin
    int mode, mode_left, hold_left, holds_done;
    m_tready <= 1'b0;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done < long_holds_asked) begin
        holds_done++;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          2: m_tready <= ($urandom_range(0, 4) == 0);
          default: m_tready <= (mode_left % 5 < 2);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst === 1'b0 && m_tvalid && m_tready) begin
      model.check_answer(m_tuser[0], m_tdata[9:0], m_tdata[19:10]);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst !== 1'b0 || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [POOL_W-1:0] phase_pool [PHASES];
    int                phase_items [PHASES];
    model = new();
    phase_pool  = '{11'd16, 11'd1024, 11'd37, 11'd3, 11'd200,
                    11'd2047, 11'd64, 11'd0, 11'd256, 11'd1};
    phase_items = '{120, 90, 120, 40, 120, 90, 130, 30, 130, 30};
    burst_left = 0;
    gapless = 1'b0;
    long_holds_asked = 0;
    rst              <= 1'b1;
    s_tvalid         <= 1'b0;
    s_tdata          <= '0;
    s_tuser          <= '0;
    pool_words_we    <= 1'b0;
    pool_words_wdata <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Pool at its reset size: splits, freeing a free block, merges, bad offsets.
    req_alloc(0);
    req_alloc(1);
    req_alloc(4);
    req_alloc(5);
    req_free(1);
    req_free(1);
    req_free(0);
    req_free(2);
    req_free(1023);
    req_alloc(8191);
    req_alloc(4096);
    req_alloc(model.largest_free() * 4);
    req_alloc(4);
    req_free(8);
    req_free(5);

    // Small pools: near fits taken whole, exact splits and offsets past the pool end.
    write_pool(11'd8);
    req_alloc(20);
    req_alloc(0);
    req_free(0);
    req_alloc(16);
    req_alloc(8);
    req_free(9);
    req_free(5);
    req_free(0);
    write_pool(11'd2);
    req_alloc(4);
    req_alloc(0);
    req_free(0);
    req_free(1);
    write_pool(11'd0);
    req_alloc(5);
    write_pool(11'd2047);
    req_alloc(4092);

    for (int ph = 0; ph < PHASES; ph++) begin
      write_pool(phase_pool[ph]);
      gapless = (ph % 3 == 1);
      for (int n = 0; n < phase_items[ph]; n++) begin
        if ((ph == 1 || ph == 6) && n == 30) long_holds_asked++;
        random_request();
      end
    end

    s_tvalid <= 1'b0;
    while (model.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (model.errors == 0 && model.outstanding() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
